@@ sv/ske_pkg.sv @@
// ----------------------------------------------------------------------------
// ske_pkg
// Shared types and constants of the scalar Kalman estimator
// ----------------------------------------------------------------------------
`default_nettype none

package ske_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int GAIN_BITS  = 16;
  localparam int GAIN_W     = GAIN_BITS + 1;
  localparam int CFG_IDX_W  = 2;

  localparam int SUM_W   = DATA_WIDTH + 1;
  localparam int MUL_A_W = DATA_WIDTH + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DELTA_W = PROD_W - GAIN_BITS;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_VAR     = 2'd0,
    REG_MEASUREMENT_VAR = 2'd1,
    REG_START_ESTIMATE  = 2'd2,
    REG_START_COVAR     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                         action;
    logic signed [DATA_WIDTH-1:0] measurement;
  } ske_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] estimate;
    logic        [DATA_WIDTH-1:0] covariance;
    logic        [GAIN_W-1:0]     gain;
  } ske_out_t;

endpackage

`default_nettype wire

@@ sv/ske_div.sv @@
// ----------------------------------------------------------------------------
// ske_div
// Restoring divider for the gain, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ske_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [ske_pkg::DATA_WIDTH-1:0]      dividend_i,
  input  wire logic [ske_pkg::SUM_W-1:0]           divisor_i,
  output logic                                     done_o,
  output logic      [ske_pkg::GAIN_BITS-1:0]       quotient_o
);

  localparam int CNT_W = $clog2(ske_pkg::GAIN_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ske_pkg::GAIN_BITS - 1);

  logic [ske_pkg::SUM_W-1:0]     rem_q, rem_d;
  logic [ske_pkg::SUM_W-1:0]     div_q;
  logic [ske_pkg::GAIN_BITS-1:0] quo_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          busy_q, done_q;
  logic [ske_pkg::SUM_W:0]       trial, dv, diff;
  logic                          ge;

  always_comb begin
    trial = {rem_q, 1'b0};
    dv    = {1'b0, div_q};
    diff  = trial - dv;
    ge    = trial >= dv;
    rem_d = ge ? diff[ske_pkg::SUM_W-1:0] : trial[ske_pkg::SUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i};
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[ske_pkg::GAIN_BITS-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ sv/ske_mul.sv @@
// ----------------------------------------------------------------------------
// ske_mul
// Shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module ske_mul (
  input  wire logic                                  clk_i,
  input  wire logic signed [ske_pkg::MUL_A_W-1:0]    a_i,
  input  wire logic signed [ske_pkg::MUL_B_W-1:0]    b_i,
  output logic signed      [ske_pkg::PROD_W-1:0]     p_o
);

  logic signed [ske_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ske_pkg::PROD_W'(a_i) * ske_pkg::PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ sv/scalar_kalman_estimator.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_estimator
// One-dimensional Kalman filter for a constant-position model, Q16.16
// ----------------------------------------------------------------------------
// An update word runs through these steps in order: the predict add, the
// divider start, the gain division (sixteen quotient bits in the divider,
// then the quotient is taken), two passes through the shared multiplier, the
// update step and the output step. With zero measurement variance the
// division is skipped. A reinitialize word goes straight from acceptance to
// its output step. The input is not ready while a word is in progress, so a
// new word is taken only after the last one has left its output step; the
// output register lets a finished result wait while the next word is taken,
// and a word that finishes while that result still waits is held in its
// output step.
`default_nettype none

module scalar_kalman_estimator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ske_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  wire logic [ske_pkg::DATA_WIDTH-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire ske_pkg::ske_in_t                    in_word_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output ske_pkg::ske_out_t                        out_word_o
);

  localparam int DW = ske_pkg::DATA_WIDTH;
  localparam int XS_W = ske_pkg::DELTA_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_PRED, S_DSTART, S_DIV, S_MULX, S_MULP, S_UPD, S_DONE
  } state_e;

  state_e state_q;

  logic [DW-1:0]        proc_var_q, meas_var_q, start_cov_q;
  logic signed [DW-1:0] start_est_q;

  logic signed [DW-1:0]                   x_q, z_q;
  logic [DW-1:0]                          cov_q, pp_q;
  logic [ske_pkg::GAIN_W-1:0]             gain_q;
  logic signed [ske_pkg::SUM_W-1:0]       diff_q;
  logic signed [ske_pkg::DELTA_W-1:0]     delta_q;
  ske_pkg::ske_out_t                      out_q;
  logic                                   out_valid_q;

  logic [ske_pkg::SUM_W-1:0]              pred_sum, gain_sum;
  logic [DW-1:0]                          psat;
  logic signed [ske_pkg::SUM_W-1:0]       diff_d;
  logic signed [XS_W-1:0]                 xs;
  logic signed [DW-1:0]                   x_sat;
  logic                                   x_ovf;
  logic signed [ske_pkg::MUL_A_W-1:0]     mul_a;
  logic signed [ske_pkg::MUL_B_W-1:0]     mul_b;
  logic signed [ske_pkg::PROD_W-1:0]      prod;
  logic                                   div_start;
  logic                                   div_done;
  logic [ske_pkg::GAIN_BITS-1:0]          quo;
  logic                                   in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_var_q  <= DW'(655);
      meas_var_q  <= DW'(262144);
      start_est_q <= '0;
      start_cov_q <= DW'(65536);
    end else if (cfg_valid_i) begin
      unique case (ske_pkg::cfg_idx_e'(cfg_addr_i))
        ske_pkg::REG_PROCESS_VAR:     proc_var_q  <= cfg_data_i;
        ske_pkg::REG_MEASUREMENT_VAR: meas_var_q  <= cfg_data_i;
        ske_pkg::REG_START_ESTIMATE:  start_est_q <= cfg_data_i;
        ske_pkg::REG_START_COVAR:     start_cov_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pred_sum = {1'b0, cov_q} + {1'b0, proc_var_q};
    psat     = pred_sum[DW] ? '1 : pred_sum[DW-1:0];
    diff_d   = {z_q[DW-1], z_q} - {x_q[DW-1], x_q};
    gain_sum = {1'b0, pp_q} + {1'b0, meas_var_q};
    xs       = {{(XS_W-DW){x_q[DW-1]}}, x_q} + {delta_q[ske_pkg::DELTA_W-1], delta_q};
    x_ovf    = (xs[XS_W-1:DW-1] != '0) && (xs[XS_W-1:DW-1] != '1);
    x_sat    = x_ovf ? (xs[XS_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}})
                     : xs[DW-1:0];
    if (state_q == S_MULP) begin
      mul_a = {1'b0, pp_q};
      mul_b = {1'b0, ske_pkg::GAIN_ONE - gain_q};
    end else begin
      mul_a = diff_q;
      mul_b = {1'b0, gain_q};
    end
    div_start = (state_q == S_DSTART) && (meas_var_q != '0);
  end

  ske_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pp_q),
    .divisor_i  (gain_sum),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  ske_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      cov_q       <= DW'(65536);
      gain_q      <= '0;
      z_q         <= '0;
      pp_q        <= '0;
      diff_q      <= '0;
      delta_q     <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            z_q <= in_word_i.measurement;
            if (in_word_i.action) begin
              x_q     <= start_est_q;
              cov_q   <= start_cov_q;
              gain_q  <= '0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_PRED;
            end
          end
        end
        S_PRED: begin
          pp_q    <= psat;
          diff_q  <= diff_d;
          state_q <= S_DSTART;
        end
        S_DSTART: begin
          if (meas_var_q == '0) begin
            gain_q  <= (pp_q == '0) ? '0 : ske_pkg::GAIN_ONE;
            state_q <= S_MULX;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            gain_q  <= {1'b0, quo};
            state_q <= S_MULX;
          end
        end
        S_MULX: state_q <= S_MULP;
        S_MULP: begin
          delta_q <= prod[ske_pkg::PROD_W-1:ske_pkg::GAIN_BITS];
          state_q <= S_UPD;
        end
        S_UPD: begin
          cov_q   <= prod[ske_pkg::GAIN_BITS +: DW];
          x_q     <= x_sat;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.estimate   <= x_q;
            out_q.covariance <= cov_q;
            out_q.gain       <= gain_q;
            out_valid_q      <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_gain_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.gain <= ske_pkg::GAIN_ONE))
    else $error("gain above one");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the division phase");

  a_reinit_fast : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.action) |=> (state_q == S_DONE && gain_q == '0))
    else $error("reinitialize word did not go straight to output");

endmodule

`default_nettype wire
